// ===== src/i2c_master_command_sequencer_defines.svh =====
// Assertion macros for the I2C master command sequencer.
// Included by the RTL files that carry concurrent assertions.
`ifndef I2C_MASTER_COMMAND_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_COMMAND_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/imcs_pkg.sv =====
// Package for the I2C master command sequencer: states, opcodes, event codes,
// and the controller/datapath interface structs. No dependencies.
`default_nettype none
package imcs_pkg;
   typedef enum logic [3:0] {
      ST_NULL = 4'd0, ST_FREE = 4'd1, ST_START = 4'd2, ST_ADDR = 4'd3,
      ST_TXMOD = 4'd4, ST_RXMOD = 4'd5, ST_RX = 4'd6, ST_TX = 4'd7,
      ST_STOP = 4'd8, ST_ERROR = 4'd9
   } state_type;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_START = 3'd2;
   localparam logic [2:0] OP_EVENT = 3'd3;
   localparam logic [2:0] OP_BUSERR = 3'd4;
   localparam logic [2:0] OP_REINIT = 3'd5;

   localparam logic [2:0] EV_START = 3'd0;
   localparam logic [2:0] EV_TXSEL = 3'd1;
   localparam logic [2:0] EV_RXSEL = 3'd2;
   localparam logic [2:0] EV_RXBYTE = 3'd3;
   localparam logic [2:0] EV_TXBYTE = 3'd4;

   localparam logic [1:0] ACK_NONE = 2'd0;
   localparam logic [1:0] ACK_ENABLE = 2'd1;
   localparam logic [1:0] ACK_DISABLE = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ADDR = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;

   // status from datapath to controller
   typedef struct packed {
      logic q_full;
      logic q_empty;
      logic fill_ok;
      logic tx_more;
      logic rx_nonzero;
      logic rxl_le1;
      logic left_one;
      logic left_zero;
      logic tail;
      logic wd_trip;
   } dp_status_type;

   // commands from controller to datapath
   typedef struct packed {
      logic enqueue;
      logic stage;
      logic launch;
      logic reinit;
      logic wd_count;
      logic wd_clear;
      logic idx_clear;
      logic idx_inc;
      logic dir_set;
   } dp_cmd_type;
endpackage
`default_nettype wire

// ===== src/i2c_master_command_sequencer.sv =====
// I2C master command sequencer.
// Channels: req_ (one command/event beat in), rsp_ (one result beat out per
// request beat), csr_ (event_limit write, reset value 100).
// Each request beat is processed combinationally when accepted; its result beat
// appears in the output register on the next cycle and one beat is produced
// for every request. A new request is accepted while the output register is
// empty or being taken in the same cycle, so the block sustains one beat per
// cycle; when the receiver stalls, the result beat holds and req_ready drops
// until it is taken.
// Reset is synchronous: queue empty, bus state null (reinit needed before
// start), watchdog counter zero, event_limit 100. Queue contents are
// undefined until written. The csr_ port is always ready and should only be
// written while idle.
// Depends on imcs_pkg, imcs_controller, imcs_datapath.
`default_nettype none
`include "i2c_master_command_sequencer_defines.svh"
module i2c_master_command_sequencer #(
   parameter int QUEUE_DEPTH = 8,
   parameter int MAX_WRITE_BYTES = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_op,
   input  wire logic [7:0] req_slave_addr,
   input  wire logic [4:0] req_tx_len,
   input  wire logic [7:0] req_rx_len,
   input  wire logic       req_tail_flag,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [2:0] req_event_code,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_accepted,
   output logic            rsp_start_request,
   output logic            rsp_stop_request,
   output logic [1:0]      rsp_ack_action,
   output logic [1:0]      rsp_byte_kind,
   output logic [7:0]      rsp_byte_out,
   output logic            rsp_rx_store,
   output logic [7:0]      rsp_rx_index,
   output logic [7:0]      rsp_rx_byte,
   output logic            rsp_task_done,
   output logic [3:0]      rsp_bus_state,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_data
);
   import imcs_pkg::*;
   logic step;
   dp_cmd_type cmd;
   dp_status_type status;
   logic [7:0] limit_ff, addr_byte, data_out, rx_idx;
   logic acc, sreq, preq, sel_addr, rxs, done;
   logic [1:0] ack, kind;
   state_type st_next;
   logic valid_ff;
   logic data_sel_ff;
   logic [7:0] byte_ff;

   assign req_ready = !valid_ff || rsp_ready;
   assign step = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = valid_ff;
   assign rsp_byte_out = data_sel_ff ? data_out : byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 8'd100;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   imcs_controller u_ctrl (
      .clock(clock), .reset(reset), .step(step), .op(req_op),
      .event_code(req_event_code), .status(status), .cmd(cmd),
      .accepted(acc), .start_req(sreq), .stop_req(preq), .ack_action(ack),
      .byte_kind(kind), .sel_addr(sel_addr), .rx_store(rxs),
      .task_done(done), .state_next(st_next)
   );

   imcs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_WRITE_BYTES(MAX_WRITE_BYTES)) u_dp (
      .clock(clock), .reset(reset), .step(step), .cmd(cmd), .status(status),
      .slave_addr(req_slave_addr), .tx_len(req_tx_len), .rx_len(req_rx_len),
      .tail_flag(req_tail_flag), .data_byte(req_data_byte),
      .event_limit(limit_ff), .addr_byte(addr_byte), .data_out(data_out),
      .rx_idx(rx_idx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (step) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_accepted <= acc;
         rsp_start_request <= sreq;
         rsp_stop_request <= preq;
         rsp_ack_action <= ack;
         rsp_byte_kind <= kind;
         data_sel_ff <= (kind == KIND_DATA);
         byte_ff <= sel_addr ? addr_byte : 8'd0;
         rsp_rx_store <= rxs;
         rsp_rx_index <= rxs ? rx_idx : 8'd0;
         rsp_rx_byte <= rxs ? req_data_byte : 8'd0;
         rsp_task_done <= done;
         rsp_bus_state <= st_next;
      end
   end

   `ASSERT_NEXT(a_step_valid, clock, reset, step, rsp_valid)
   `ASSERT_IMPL(a_stall_block, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_bus_state))
endmodule
`default_nettype wire

// ===== src/imcs_datapath.sv =====
// Datapath: command queue, staged write-byte memory, current command, byte
// index and watchdog counter. Depends on imcs_pkg.
`default_nettype none
module imcs_datapath #(
   parameter int QUEUE_DEPTH = 8,
   parameter int MAX_WRITE_BYTES = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire imcs_pkg::dp_cmd_type   cmd,
   output imcs_pkg::dp_status_type     status,
   input  wire logic [7:0]             slave_addr,
   input  wire logic [4:0]             tx_len,
   input  wire logic [7:0]             rx_len,
   input  wire logic                   tail_flag,
   input  wire logic [7:0]             data_byte,
   input  wire logic [7:0]             event_limit,
   output logic [7:0]                  addr_byte,
   output logic [7:0]                  data_out,
   output logic [7:0]                  rx_idx
);
   import imcs_pkg::*;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int FW = $clog2(MAX_WRITE_BYTES + 1);
   localparam int MW = (QUEUE_DEPTH * MAX_WRITE_BYTES > 1) ?
                       $clog2(QUEUE_DEPTH * MAX_WRITE_BYTES) : 1;

   typedef struct packed {
      logic [7:0]    addr;
      logic [FW-1:0] txl;
      logic [7:0]    rxl;
      logic          tail;
      logic [QW-1:0] slot;
   } hdr_type;

   hdr_type hdr_mem [QUEUE_DEPTH];
   logic [7:0] byte_mem [QUEUE_DEPTH * MAX_WRITE_BYTES];

   logic [QW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [FW-1:0] fill_ff, fill_in;
   hdr_type cur_ff, cur_in;
   logic [7:0] idx_ff, idx_in;
   logic dir_ff, dir_in;
   logic [7:0] wd_ff, wd_in;
   logic [QW-1:0] tail_slot;
   logic [QW:0] tail_sum;
   logic [FW-1:0] txl_sat;
   hdr_type new_hdr;
   logic [MW-1:0] wr_addr, rd_addr;
   logic [7:0] rd_ff;
   logic rd_ok_ff;
   logic [7:0] idx_nx;
   logic [8:0] left;

   assign tail_sum = {1'b0, head_ff} + (QW+1)'(count_ff);
   assign tail_slot = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                      QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
   assign txl_sat = ({3'b0, tx_len} > 8'(MAX_WRITE_BYTES)) ?
                    FW'(MAX_WRITE_BYTES) : FW'(tx_len);
   assign new_hdr = '{addr: slave_addr, txl: txl_sat, rxl: rx_len,
                      tail: tail_flag, slot: tail_slot};
   assign wr_addr = MW'(tail_slot * MAX_WRITE_BYTES) + MW'(fill_ff);
   assign rd_addr = MW'(cur_ff.slot * MAX_WRITE_BYTES) + MW'(idx_ff);
   assign idx_nx = idx_ff + 8'd1;
   assign left = {1'b0, cur_ff.rxl} - {1'b0, idx_nx};

   always_comb begin
      status.q_full = (count_ff == CW'(QUEUE_DEPTH));
      status.q_empty = (count_ff == '0);
      status.fill_ok = (fill_ff < FW'(MAX_WRITE_BYTES));
      status.tx_more = (8'(cur_ff.txl) > idx_ff);
      status.rx_nonzero = (cur_ff.rxl != 8'd0);
      status.rxl_le1 = (cur_ff.rxl <= 8'd1);
      status.left_one = (left == 9'd1);
      status.left_zero = (left == 9'd0);
      status.tail = cur_ff.tail;
      status.wd_trip = (wd_ff >= event_limit);
   end

   assign addr_byte = {cur_ff.addr[7:1], dir_ff};
   assign data_out = rd_ok_ff ? rd_ff : 8'd0;
   assign rx_idx = idx_ff;

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      fill_in = fill_ff;
      cur_in = cur_ff;
      idx_in = idx_ff;
      dir_in = dir_ff;
      wd_in = wd_ff;
      if (cmd.wd_count) begin
         wd_in = wd_ff + 8'd1;
      end
      if (cmd.wd_clear) begin
         wd_in = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_nx;
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end
      if (cmd.dir_set) begin
         dir_in = 1'b1;
      end
      if (cmd.enqueue) begin
         count_in = count_ff + CW'(1);
         fill_in = '0;
      end
      if (cmd.stage) begin
         fill_in = fill_ff + FW'(1);
      end
      if (cmd.launch) begin
         cur_in = hdr_mem[head_ff];
         head_in = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QW'(1);
         count_in = count_ff - CW'(1);
         idx_in = '0;
         dir_in = (hdr_mem[head_ff].txl == '0);
      end
      if (cmd.reinit) begin
         head_in = '0;
         count_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
         fill_ff <= '0;
         cur_ff <= '0;
         idx_ff <= '0;
         dir_ff <= 1'b0;
         wd_ff <= '0;
      end else if (step) begin
         head_ff <= head_in;
         count_ff <= count_in;
         fill_ff <= fill_in;
         cur_ff <= cur_in;
         idx_ff <= idx_in;
         dir_ff <= dir_in;
         wd_ff <= wd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rd_ff <= byte_mem[rd_addr];
         rd_ok_ff <= (idx_ff < 8'(MAX_WRITE_BYTES));
         if (cmd.enqueue) begin
            hdr_mem[tail_slot] <= new_hdr;
         end
         if (cmd.stage) begin
            byte_mem[wr_addr] <= data_byte;
         end
      end
   end
endmodule
`default_nettype wire

// ===== src/imcs_controller.sv =====
// Controller: bus state machine, decodes ops and bus events into datapath
// commands and the result beat. Depends on imcs_pkg and the defines header.
`default_nettype none
`include "i2c_master_command_sequencer_defines.svh"
module imcs_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [2:0]             op,
   input  wire logic [2:0]             event_code,
   input  wire imcs_pkg::dp_status_type status,
   output imcs_pkg::dp_cmd_type        cmd,
   output logic                        accepted,
   output logic                        start_req,
   output logic                        stop_req,
   output logic [1:0]                  ack_action,
   output logic [1:0]                  byte_kind,
   output logic                        sel_addr,
   output logic                        rx_store,
   output logic                        task_done,
   output imcs_pkg::state_type         state_next
);
   import imcs_pkg::*;
   state_type state_ff, state_in, st;
   logic do_launch, do_complete;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_NULL;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd = '0;
      accepted = 1'b0;
      start_req = 1'b0;
      stop_req = 1'b0;
      ack_action = ACK_NONE;
      byte_kind = KIND_NONE;
      sel_addr = 1'b0;
      rx_store = 1'b0;
      task_done = 1'b0;
      do_launch = 1'b0;
      do_complete = 1'b0;
      st = state_ff;
      case (op)
         OP_ADD: begin
            if (!status.q_full) begin
               cmd.enqueue = 1'b1;
               accepted = 1'b1;
            end
         end
         OP_WRITE: begin
            if (!status.q_full && status.fill_ok) begin
               cmd.stage = 1'b1;
               accepted = 1'b1;
            end
         end
         OP_START: begin
            if (state_ff == ST_FREE && !status.q_empty) begin
               do_launch = 1'b1;
               accepted = 1'b1;
            end
         end
         OP_EVENT: begin
            if (status.wd_trip) begin
               st = ST_ERROR;
               cmd.wd_clear = 1'b1;
            end else begin
               cmd.wd_count = 1'b1;
            end
            case (event_code)
               EV_START: begin
                  st = ST_ADDR;
                  cmd.idx_clear = 1'b1;
                  byte_kind = KIND_ADDR;
                  sel_addr = 1'b1;
               end
               EV_TXSEL: begin
                  st = ST_TXMOD;
                  byte_kind = KIND_DATA;
                  cmd.idx_inc = 1'b1;
               end
               EV_RXSEL: begin
                  st = ST_RXMOD;
                  if (status.rxl_le1) begin
                     ack_action = ACK_DISABLE;
                     stop_req = 1'b1;
                  end
               end
               EV_RXBYTE: begin
                  st = ST_RX;
                  rx_store = 1'b1;
                  cmd.idx_inc = 1'b1;
                  if (status.left_one) begin
                     ack_action = ACK_DISABLE;
                     stop_req = 1'b1;
                  end else if (status.left_zero) begin
                     do_complete = 1'b1;
                  end
               end
               EV_TXBYTE: begin
                  if (status.tx_more) begin
                     st = ST_TX;
                     byte_kind = KIND_DATA;
                     cmd.idx_inc = 1'b1;
                  end else if (status.rx_nonzero) begin
                     st = ST_START;
                     cmd.idx_clear = 1'b1;
                     cmd.dir_set = 1'b1;
                     start_req = 1'b1;
                  end else begin
                     stop_req = 1'b1;
                     do_complete = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_BUSERR: begin
            st = ST_ERROR;
         end
         OP_REINIT: begin
            cmd.reinit = 1'b1;
            st = ST_FREE;
         end
         default: begin
         end
      endcase
      if (do_complete) begin
         cmd.wd_clear = 1'b1;
         cmd.wd_count = 1'b0;
         task_done = status.tail;
         st = ST_STOP;
         if (status.q_empty) begin
            st = ST_FREE;
         end else begin
            do_launch = 1'b1;
         end
      end
      if (do_launch) begin
         cmd.launch = 1'b1;
         cmd.idx_inc = 1'b0;
         st = ST_START;
         ack_action = ACK_ENABLE;
         start_req = 1'b1;
      end
      state_in = st;
      state_next = st;
   end

   `ASSERT_IMPL(a_launch_start, clock, reset, cmd.launch, start_req)
   `ASSERT_IMPL(a_done_stop, clock, reset, task_done, cmd.wd_clear)
   `ASSERT_IMPL(a_store_rx, clock, reset, rx_store, state_next != ST_ERROR)
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for i2c_master_command_sequencer: drives command and bus-event
// beats, predicts every result beat and checks it. Depends on imcs_pkg.
`timescale 1ns / 1ps
module testbench;
   import imcs_pkg::*;

   typedef struct {
      logic [2:0] op;
      logic [7:0] addr;
      logic [4:0] txl;
      logic [7:0] rxl;
      logic       tail;
      logic [7:0] db;
      logic [2:0] ev;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic       start_req;
      logic       stop_req;
      logic [1:0] ack;
      logic [1:0] kind;
      logic [7:0] byte_out;
      logic       rx_store;
      logic [7:0] rx_index;
      logic [7:0] rx_byte;
      logic       done;
      logic [3:0] bus;
   } rsp_type;

   typedef struct {
      logic [7:0] addr;
      logic [4:0] txl;
      logic [7:0] rxl;
      logic       tail;
      logic [2:0] slot;
   } cmd_type;

   localparam int DEPTH = 8;
   localparam int MAXW = 16;
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam logic [2:0] EV_OTHER = 3'd5;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [2:0] req_op = 0;
   logic [7:0] req_slave_addr = 0;
   logic [4:0] req_tx_len = 0;
   logic [7:0] req_rx_len = 0;
   logic req_tail_flag = 0;
   logic [7:0] req_data_byte = 0;
   logic [2:0] req_event_code = 0;
   logic rsp_valid, rsp_ready = 0;
   logic rsp_accepted, rsp_start_request, rsp_stop_request, rsp_rx_store, rsp_task_done;
   logic [1:0] rsp_ack_action, rsp_byte_kind;
   logic [7:0] rsp_byte_out, rsp_rx_index, rsp_rx_byte;
   logic [3:0] rsp_bus_state;
   logic csr_valid = 0, csr_ready;
   logic [7:0] csr_data = 0;

   i2c_master_command_sequencer dut (.*);

   always #2 clock = ~clock;

   // sequencer shadow state
   logic [7:0] limit_reg;
   cmd_type hdrs [DEPTH];
   logic [7:0] wbytes [DEPTH][MAXW];
   int q_head, q_count, fill;
   cmd_type cur;
   logic [7:0] idx;
   logic dir_rd;
   state_type mstate;
   logic [7:0] wd_count;

   req_type pending_beats[$];
   rsp_type expected_beats[$];
   int mismatches = 0;
   int send_idle = 0, recv_stall = 0;
   logic hold_req = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   task launch_next(inout rsp_type o, output bit ok);
      ok = 0;
      if (mstate == ST_FREE || mstate == ST_STOP) begin
         if (q_count == 0) begin
            mstate = ST_FREE;
         end else begin
            cur = hdrs[q_head];
            q_head = (q_head + 1) % DEPTH;
            q_count--;
            mstate = ST_START;
            idx = 0;
            dir_rd = (cur.txl == 0);
            o.ack = ACK_ENABLE;
            o.start_req = 1;
            ok = 1;
         end
      end
   endtask

   task finish_cmd(inout rsp_type o);
      bit ok;
      mstate = ST_STOP;
      wd_count = 0;
      if (cur.tail) o.done = 1;
      launch_next(o, ok);
   endtask

   task send_data(inout rsp_type o);
      o.kind = KIND_DATA;
      o.byte_out = (idx < MAXW) ? wbytes[cur.slot][idx[3:0]] : 8'd0;
      idx = idx + 8'd1;
   endtask

   task predict_beat(input req_type r, output rsp_type o);
      int ts;
      int left;
      bit ok;
      o = '0;
      ts = (q_head + q_count) % DEPTH;
      case (r.op)
         OP_ADD: if (q_count < DEPTH) begin
            hdrs[ts].addr = r.addr;
            hdrs[ts].txl = (r.txl > MAXW) ? 5'(MAXW) : r.txl;
            hdrs[ts].rxl = r.rxl;
            hdrs[ts].tail = r.tail;
            hdrs[ts].slot = 3'(ts);
            q_count++;
            fill = 0;
            o.accepted = 1;
         end
         OP_WRITE: if (q_count < DEPTH && fill < MAXW) begin
            wbytes[ts][fill] = r.db;
            fill++;
            o.accepted = 1;
         end
         OP_START: if (mstate == ST_FREE) begin
            launch_next(o, ok);
            o.accepted = ok;
         end
         OP_EVENT: begin
            if (wd_count >= limit_reg) begin
               mstate = ST_ERROR;
               wd_count = 0;
            end else begin
               wd_count = wd_count + 8'd1;
            end
            case (r.ev)
               EV_START: begin
                  mstate = ST_ADDR;
                  idx = 0;
                  o.kind = KIND_ADDR;
                  o.byte_out = {cur.addr[7:1], dir_rd};
               end
               EV_TXSEL: begin
                  mstate = ST_TXMOD;
                  send_data(o);
               end
               EV_RXSEL: begin
                  mstate = ST_RXMOD;
                  if (cur.rxl <= 1) begin
                     o.ack = ACK_DISABLE;
                     o.stop_req = 1;
                  end
               end
               EV_RXBYTE: begin
                  mstate = ST_RX;
                  o.rx_store = 1;
                  o.rx_index = idx;
                  o.rx_byte = r.db;
                  idx = idx + 8'd1;
                  left = int'(cur.rxl) - int'(idx);
                  if (left == 1) begin
                     o.ack = ACK_DISABLE;
                     o.stop_req = 1;
                  end else if (left == 0) begin
                     finish_cmd(o);
                  end
               end
               EV_TXBYTE: begin
                  if (idx < cur.txl) begin
                     mstate = ST_TX;
                     send_data(o);
                  end else if (cur.rxl > 0) begin
                     mstate = ST_START;
                     idx = 0;
                     dir_rd = 1;
                     o.start_req = 1;
                  end else begin
                     o.stop_req = 1;
                     finish_cmd(o);
                  end
               end
               default: ;
            endcase
         end
         OP_BUSERR: mstate = ST_ERROR;
         OP_REINIT: begin
            q_head = 0;
            q_count = 0;
            fill = 0;
            mstate = ST_FREE;
         end
         default: ;
      endcase
      o.bus = mstate;
   endtask

   // driver
   always @(posedge clock) begin
      rsp_type exp_beat;
      req_type nxt;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (csr_valid && csr_ready) limit_reg = csr_data;
         if (req_valid && req_ready) begin
            predict_beat('{req_op, req_slave_addr, req_tx_len, req_rx_len, req_tail_flag,
                           req_data_byte, req_event_code}, exp_beat);
            expected_beats.push_back(exp_beat);
         end
         if (!req_valid || req_ready) begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
               nxt = pending_beats.pop_front();
               req_valid <= 1;
               req_op <= nxt.op;
               req_slave_addr <= nxt.addr;
               req_tx_len <= nxt.txl;
               req_rx_len <= nxt.rxl;
               req_tail_flag <= nxt.tail;
               req_data_byte <= nxt.db;
               req_event_code <= nxt.ev;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_req) hold_left <= 300;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // monitor
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_accepted, rsp_start_request, rsp_stop_request, rsp_ack_action,
                   rsp_byte_kind, rsp_byte_out, rsp_rx_store, rsp_rx_index, rsp_rx_byte,
                   rsp_task_done, rsp_bus_state};
            if (expected_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
               want = expected_beats.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_type mk(logic [2:0] op, logic [7:0] db = 0, logic [2:0] ev = 0);
      req_type r;
      r = '{op, 8'($urandom), 5'($urandom), 8'($urandom), 1'($urandom), db, ev};
      return r;
   endfunction

   function automatic req_type mk_add(logic [7:0] a, logic [4:0] t, logic [7:0] rl, logic tl);
      req_type r;
      r = mk(OP_ADD);
      r.addr = a;
      r.txl = t;
      r.rxl = rl;
      r.tail = tl;
      return r;
   endfunction

   function automatic req_type mk_ev(logic [2:0] ev);
      return mk(OP_EVENT, 8'($urandom), ev);
   endfunction

   task add_noise();
      req_type r;
      r = '{3'($urandom), 8'($urandom), 5'($urandom), 8'($urandom), 1'($urandom),
            8'($urandom), 3'($urandom)};
      pending_beats.push_back(r);
   endtask

   // one transfer episode: optional reinit, stage, queue, start, then play the bus events, with occasional noise beats
   task add_episode();
      int ncmd, nbytes;
      logic [4:0] t [3];
      logic [7:0] rl [3];
      ncmd = $urandom_range(1, 3);
      if ($urandom_range(9) == 0) pending_beats.push_back(mk(OP_REINIT));
      for (int c = 0; c < ncmd; c++) begin
         t[c] = ($urandom_range(9) == 0) ? 5'($urandom_range(16, 31)) : 5'($urandom_range(4));
         rl[c] = ($urandom_range(19) == 0) ? 8'($urandom_range(5, 255)) : 8'($urandom_range(4));
         nbytes = $urandom_range(0, 18);
         for (int b = 0; b < nbytes; b++) pending_beats.push_back(mk(OP_WRITE, 8'($urandom)));
         pending_beats.push_back(mk_add(8'($urandom), t[c], rl[c], 1'($urandom)));
      end
      pending_beats.push_back(mk(OP_START));
      for (int c = 0; c < ncmd; c++) begin
         pending_beats.push_back(mk_ev(EV_START));
         if (t[c] != 0) begin
            pending_beats.push_back(mk_ev(EV_TXSEL));
            for (int b = 0; b < ((t[c] > 16) ? 16 : t[c]); b++)
               pending_beats.push_back(mk_ev(EV_TXBYTE));
            if (rl[c] != 0) pending_beats.push_back(mk_ev(EV_START));
         end
         if (rl[c] != 0 || t[c] == 0) begin
            pending_beats.push_back(mk_ev(EV_RXSEL));
            for (int b = 0; b < rl[c]; b++) pending_beats.push_back(mk_ev(EV_RXBYTE));
         end
         if ($urandom_range(9) == 0) add_noise();
      end
      if ($urandom_range(4) == 0) add_noise();
   endtask

   task drain();
      wait (pending_beats.size() == 0 && !req_valid && expected_beats.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task write_limit(logic [7:0] v);
      drain();
      @(posedge clock);
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   initial begin
      int sent;
      logic [7:0] fill_byte;
      limit_reg = 100;
      q_head = 0; q_count = 0; fill = 0;
      cur = '{0, 0, 0, 0, 0};
      idx = 0; dir_rd = 0; mstate = ST_NULL; wd_count = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // null state: start and unused codes do nothing
      pending_beats.push_back(mk(OP_START));
      pending_beats.push_back(mk(OP_SPARE_A));
      pending_beats.push_back(mk(OP_SPARE_B));
      pending_beats.push_back(mk(OP_EVENT, 8'hFF, EV_OTHER));
      // fill every write slot so no byte read is undefined
      for (int s = 0; s < DEPTH; s++) begin
         for (int b = 0; b < MAXW; b++) begin
            fill_byte = (s == 0) ? 8'h00 : ((s == 1) ? 8'hFF : 8'($urandom));
            pending_beats.push_back(mk(OP_WRITE, fill_byte));
         end
         pending_beats.push_back(mk_add((s == 0) ? 8'h00 : 8'hFF, 5'd31, 8'd255, 1'b1));
      end
      // full queue: add and stage rejected
      pending_beats.push_back(mk(OP_WRITE, 8'h5A));
      pending_beats.push_back(mk_add(8'h12, 5'd1, 8'd1, 1'b0));
      pending_beats.push_back(mk(OP_REINIT));
      for (int b = 0; b < 17; b++) pending_beats.push_back(mk(OP_WRITE, 8'(b)));
      pending_beats.push_back(mk_add(8'hA5, 5'd2, 8'd2, 1'b1));
      pending_beats.push_back(mk(OP_START));
      pending_beats.push_back(mk(OP_START));
      pending_beats.push_back(mk_ev(EV_START));
      pending_beats.push_back(mk_ev(EV_TXSEL));
      pending_beats.push_back(mk_ev(EV_TXBYTE));
      pending_beats.push_back(mk_ev(EV_TXBYTE));
      pending_beats.push_back(mk_ev(EV_START));
      pending_beats.push_back(mk_ev(EV_RXSEL));
      pending_beats.push_back(mk_ev(EV_RXBYTE));
      pending_beats.push_back(mk_ev(EV_RXBYTE));
      pending_beats.push_back(mk_ev(EV_TXSEL));
      pending_beats.push_back(mk(OP_BUSERR));
      pending_beats.push_back(mk(OP_START));
      pending_beats.push_back(mk(OP_REINIT));
      pending_beats.push_back(mk(OP_START));

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_limit(8'd255);
            1: write_limit(8'd1);
            2: write_limit(8'd100);
            3: write_limit(8'($urandom_range(1, 255)));
            default: write_limit(8'd255);
         endcase
         send_idle = (ph == 1 || ph == 4) ? 65 : (ph == 3 ? 27 : 0);
         recv_stall = (ph == 2 || ph == 4) ? 65 : (ph == 3 ? 27 : 0);
         sent = 0;
         if (ph == 0) begin
            hold_req <= 1;
            @(posedge clock);
            hold_req <= 0;
         end
         while (sent < 240) begin
            sent -= pending_beats.size();
            add_episode();
            sent += pending_beats.size();
            wait (pending_beats.size() < 40);
         end
      end
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
